// File: sv/iias_pkg.sv
// Shared types and fixed field widths for the integral image area-sum block.
// No dependencies; every other file except iias_ram imports this package.
`default_nettype none

package iias_pkg;

  localparam int IMG_W_BITS     = 10;
  localparam int IMG_H_BITS     = 9;
  localparam int PIXEL_BITS     = 8;
  localparam int AREA_BITS      = 32;
  localparam int CFG_DATA_BITS  = 10;

  localparam logic [IMG_W_BITS-1:0] WIDTH_RESET  = 10'd640;
  localparam logic [IMG_H_BITS-1:0] HEIGHT_RESET = 9'd480;

  typedef enum logic [0:0] {
    MODE_PIXEL = 1'b0,
    MODE_QUERY = 1'b1
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_RANGE      = 2'd1,
    ST_INCOMPLETE = 2'd2
  } status_t;

  typedef enum logic [0:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_t;

endpackage

`default_nettype wire

// File: sv/iias_item_if.sv
// Input channel: one request is either a pixel or an area query.
// Depends on iias_pkg for field widths and the mode type.
`default_nettype none

interface iias_item_if import iias_pkg::*; ();
  logic                  valid;
  logic                  ready;
  mode_t                 mode;
  logic [PIXEL_BITS-1:0] pixel;
  logic [IMG_W_BITS-1:0] corner_x0;
  logic [IMG_H_BITS-1:0] corner_y0;
  logic [IMG_W_BITS-1:0] corner_x1;
  logic [IMG_H_BITS-1:0] corner_y1;

  modport source (
    output valid, mode, pixel, corner_x0, corner_y0, corner_x1, corner_y1,
    input  ready
  );
  modport sink (
    input  valid, mode, pixel, corner_x0, corner_y0, corner_x1, corner_y1,
    output ready
  );
endinterface

`default_nettype wire

// File: sv/iias_result_if.sv
// Result channel: area sum and status of one query.
// Depends on iias_pkg for widths and the status type.
`default_nettype none

interface iias_result_if import iias_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [AREA_BITS-1:0] area_sum;
  status_t              status;

  modport source (output valid, area_sum, status, input ready);
  modport sink (input valid, area_sum, status, output ready);
endinterface

`default_nettype wire

// File: sv/iias_cfg_if.sv
// Configuration write channel: register index and write data.
// Depends on iias_pkg for the register index type and data width.
`default_nettype none

interface iias_cfg_if import iias_pkg::*; ();
  logic                     valid;
  logic                     ready;
  cfg_reg_t                 index;
  logic [CFG_DATA_BITS-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: sv/iias_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module iias_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: sv/integral_image_area_sum.sv
// Summed-area table builder with four-corner area queries.
// Depends on iias_pkg, the three channel interfaces and iias_ram.
//
//   channel  role    payload
//   item     sink    mode, pixel, corner_x0, corner_y0, corner_x1, corner_y1
//   result   source  area_sum, status
//   cfg      sink    index, data (image_width, image_height)
//
// A pixel reads the entry above, then writes the new entry.
// A valid query makes four reads of the single table read port,
// then folds in the last read and loads the output register.
// A rejected query skips the reads. The table is not cleared after reset.
// A result waiting on a stalled sink holds back only the next query.
`default_nettype none

module integral_image_area_sum import iias_pkg::*; #(
  parameter int MAX_WIDTH  = 640,
  parameter int MAX_HEIGHT = 480,
  parameter int SUM_BITS   = 32
) (
  input  logic         clk,
  input  logic         rst,
  iias_item_if.sink    item,
  iias_result_if.source result,
  iias_cfg_if.sink     cfg
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int XW    = ($clog2(MAX_WIDTH + 1) > IMG_W_BITS) ?
                         $clog2(MAX_WIDTH + 1) : IMG_W_BITS;
  localparam int YW    = ($clog2(MAX_HEIGHT + 1) > IMG_H_BITS) ?
                         $clog2(MAX_HEIGHT + 1) : IMG_H_BITS;
  localparam int SW    = (SUM_BITS > AREA_BITS) ? SUM_BITS : AREA_BITS;

  localparam logic [XW-1:0] MAX_W_X  = XW'(MAX_WIDTH);
  localparam logic [YW-1:0] MAX_H_Y  = YW'(MAX_HEIGHT);
  localparam logic [AW-1:0] ROW_STEP = AW'(MAX_WIDTH);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PIX_WR,
    S_QRUN,
    S_QLAST,
    S_QPUT
  } state_t;

  state_t                state;
  logic [IMG_W_BITS-1:0] image_width;
  logic [IMG_H_BITS-1:0] image_height;
  logic [XW-1:0]         col;
  logic [YW-1:0]         row;
  logic [AW-1:0]         row_base;
  logic [SUM_BITS-1:0]   rsum;
  logic                  complete;
  logic                  pix_top;
  logic [IMG_W_BITS-1:0] qx0, qx1;
  logic [IMG_H_BITS-1:0] qy0, qy1;
  logic [1:0]            k;
  logic                  rd_pend, rd_zero, rd_neg;
  logic [SW-1:0]         acc;
  status_t               res_status;
  logic                  out_valid;
  logic [AREA_BITS-1:0]  out_sum;
  status_t               out_status;

  logic [XW-1:0]         width_ext, w_eff, col_e, col_inc;
  logic [YW-1:0]         height_ext, h_eff, row_e, row_inc;
  logic [AW-1:0]         base_e, above_addr, corner_addr, raddr, waddr;
  logic                  accept, restart, out_of_range;
  logic [IMG_W_BITS-1:0] cx;
  logic [IMG_H_BITS-1:0] cy, cy_m1;
  logic [IMG_W_BITS-1:0] cx_m1;
  logic                  corner_neg, corner_zero;
  logic [SUM_BITS-1:0]   rd_data, above;
  logic                  we;
  logic [SW-1:0]         add_a, add_b, add_y;
  logic                  add_sub;

  // A register write takes the idle slot ahead of any request.
  assign item.ready      = (state == S_IDLE) && !cfg.valid;
  assign cfg.ready       = (state == S_IDLE);
  assign result.valid    = out_valid;
  assign result.area_sum = out_sum;
  assign result.status   = out_status;

  assign accept = item.valid && item.ready;

  // Registers are clamped to 1..MAX so odd values still give a usable frame.
  assign width_ext  = XW'(image_width);
  assign height_ext = YW'(image_height);
  assign w_eff = (image_width == '0) ? XW'(1) :
                 ((width_ext > MAX_W_X) ? MAX_W_X : width_ext);
  assign h_eff = (image_height == '0) ? YW'(1) :
                 ((height_ext > MAX_H_Y) ? MAX_H_Y : height_ext);

  // A pixel after a finished image starts a new one at the origin.
  assign restart = complete || (col >= w_eff) || (row >= h_eff);
  assign col_e   = restart ? '0 : col;
  assign row_e   = restart ? '0 : row;
  assign base_e  = restart ? '0 : row_base;
  assign above_addr = base_e + AW'(col_e) - ROW_STEP;
  assign col_inc = col + XW'(1);
  assign row_inc = row + YW'(1);

  assign out_of_range = (XW'(item.corner_x0) > w_eff) || (XW'(item.corner_x1) > w_eff) ||
                        (YW'(item.corner_y0) > h_eff) || (YW'(item.corner_y1) > h_eff);

  // Corner order: (x1,y1) added, (x1,y0) and (x0,y1) subtracted, (x0,y0) added.
  always_comb begin
    unique case (k)
      2'd0: begin cx = qx1; cy = qy1; corner_neg = 1'b0; end
      2'd1: begin cx = qx1; cy = qy0; corner_neg = 1'b1; end
      2'd2: begin cx = qx0; cy = qy1; corner_neg = 1'b1; end
      default: begin cx = qx0; cy = qy0; corner_neg = 1'b0; end
    endcase
  end

  assign corner_zero = (cx == '0) || (cy == '0);
  assign cx_m1       = cx - IMG_W_BITS'(1);
  assign cy_m1       = cy - IMG_H_BITS'(1);
  assign corner_addr = AW'(cy_m1) * ROW_STEP + AW'(cx_m1);

  assign raddr = (state == S_QRUN) ? corner_addr : above_addr;
  assign we    = (state == S_PIX_WR);
  assign waddr = row_base + AW'(col);
  assign above = pix_top ? '0 : rd_data;

  // The one adder serves both the table update and the query accumulation.
  always_comb begin
    if (state == S_PIX_WR) begin
      add_a   = SW'(above);
      add_b   = SW'(rsum);
      add_sub = 1'b0;
    end else begin
      add_a   = acc;
      add_b   = rd_zero ? '0 : SW'(rd_data);
      add_sub = rd_neg;
    end
  end

  assign add_y = add_sub ? (add_a - add_b) : (add_a + add_b);

  iias_ram #(
    .WIDTH (SUM_BITS),
    .DEPTH (DEPTH),
    .ADDR_W(AW)
  ) u_table (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(add_y[SUM_BITS-1:0]),
    .raddr(raddr),
    .rdata(rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
      col          <= '0;
      row          <= '0;
      row_base     <= '0;
      rsum         <= '0;
      complete     <= 1'b0;
      rd_pend      <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      rd_pend <= 1'b0;
      if (result.ready && (state != S_QPUT)) begin
        out_valid <= 1'b0;
      end
      if (rd_pend) begin
        acc <= add_y;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (item.mode == MODE_PIXEL) begin
              col      <= col_e;
              row      <= row_e;
              row_base <= base_e;
              rsum     <= (restart ? '0 : rsum) + SUM_BITS'(item.pixel);
              pix_top  <= (row_e == '0);
              complete <= 1'b0;
              state    <= S_PIX_WR;
            end else begin
              qx0 <= item.corner_x0;
              qy0 <= item.corner_y0;
              qx1 <= item.corner_x1;
              qy1 <= item.corner_y1;
              acc <= '0;
              k   <= '0;
              if (!complete) begin
                res_status <= ST_INCOMPLETE;
                state      <= S_QPUT;
              end else if (out_of_range) begin
                res_status <= ST_RANGE;
                state      <= S_QPUT;
              end else begin
                res_status <= ST_OK;
                state      <= S_QRUN;
              end
            end
          end
        end
        S_PIX_WR: begin
          if (col_inc >= w_eff) begin
            col  <= '0;
            rsum <= '0;
            if (row_inc >= h_eff) begin
              row      <= '0;
              row_base <= '0;
              complete <= 1'b1;
            end else begin
              row      <= row_inc;
              row_base <= row_base + ROW_STEP;
            end
          end else begin
            col <= col_inc;
          end
          state <= S_IDLE;
        end
        S_QRUN: begin
          rd_pend <= 1'b1;
          rd_zero <= corner_zero;
          rd_neg  <= corner_neg;
          k       <= k + 2'd1;
          if (k == 2'd3) begin
            state <= S_QLAST;
          end
        end
        S_QLAST: begin
          state <= S_QPUT;
        end
        S_QPUT: begin
          if (!out_valid || result.ready) begin
            out_valid  <= 1'b1;
            out_sum    <= AREA_BITS'(acc);
            out_status <= res_status;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      // Any register write restarts image building.
      if (cfg.valid && cfg.ready) begin
        unique case (cfg.index)
          REG_IMAGE_WIDTH:  image_width  <= cfg.data[IMG_W_BITS-1:0];
          REG_IMAGE_HEIGHT: image_height <= cfg.data[IMG_H_BITS-1:0];
        endcase
        col      <= '0;
        row      <= '0;
        row_base <= '0;
        rsum     <= '0;
        complete <= 1'b0;
      end
    end
  end

  a_reject_zero_sum: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.status != ST_OK) |-> (result.area_sum == '0))
    else $error("rejected query carries a nonzero area sum");

  a_col_in_frame: assert property (@(posedge clk) disable iff (rst)
    (state == S_PIX_WR) |=> (col < w_eff))
    else $error("column position left the frame after a pixel write");

  a_complete_at_origin: assert property (@(posedge clk) disable iff (rst)
    $rose(complete) |-> (col == '0 && row == '0 && rsum == '0))
    else $error("image completed away from the origin");

  a_row_base_tracks_row: assert property (@(posedge clk) disable iff (rst)
    (state == S_PIX_WR) |-> (row_base == AW'(row) * ROW_STEP))
    else $error("row base address out of step with row position");

endmodule

`default_nettype wire

// File: tb/sv/testbench.sv
// Self-checking testbench for integral_image_area_sum: builds summed-area tables from
// pixel streams and checks every area query against an in-bench table model or a directed expected value.
// Depends on iias_pkg, the three channel interfaces and the block itself.
`timescale 1ns / 1ps

module testbench;
  import iias_pkg::*;

  localparam int SAT_COLS     = 640;
  localparam int SAT_ROWS     = 480;
  localparam int SETTLE_CYC   = 12;
  localparam int LONG_HOLD    = 300;
  localparam int ITEM_TARGET  = 1650;
  localparam int QUIET_FROM   = 1450;
  localparam int CYCLE_LIMIT  = 250000;

  typedef struct {
    mode_t                 mode;
    logic [PIXEL_BITS-1:0] pixel;
    logic [IMG_W_BITS-1:0] x0;
    logic [IMG_H_BITS-1:0] y0;
    logic [IMG_W_BITS-1:0] x1;
    logic [IMG_H_BITS-1:0] y1;
  } sat_req_t;

  typedef struct {
    logic [AREA_BITS-1:0] area;
    status_t              status;
  } sat_resp_t;

  typedef struct {
    bit                       is_cfg;
    cfg_reg_t                 idx;
    logic [CFG_DATA_BITS-1:0] data;
    sat_req_t                 req;
    bit                       typed;
    sat_resp_t                want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst;

  iias_item_if   item_ch ();
  iias_result_if result_ch ();
  iias_cfg_if    cfg_ch ();

  integral_image_area_sum #(
    .MAX_WIDTH (SAT_COLS),
    .MAX_HEIGHT(SAT_ROWS),
    .SUM_BITS  (32)
  ) uut (
    .clk   (clk),
    .rst   (rst),
    .item  (item_ch),
    .result(result_ch),
    .cfg   (cfg_ch)
  );

  always #4 clk = ~clk;

  // Table model state.
  bit [31:0]   sat_mem [SAT_COLS*SAT_ROWS];
  bit [31:0]   row_acc;
  int unsigned col_pos;
  int unsigned row_pos;
  bit          img_done;
  int unsigned reg_w;
  int unsigned reg_h;

  sat_resp_t   pending_sums [$];
  dir_row_t    dir_rows [$];
  sat_resp_t   got_want;
  sat_resp_t   no_want;
  int unsigned items_sent;
  int unsigned sums_checked;
  int unsigned error_count;
  int unsigned cycle_count;
  int unsigned phase_no;
  bit          quiet;
  bit          send_calm;
  bit          hold_go;

  function automatic int unsigned eff_w();
    if (reg_w < 1) return 1;
    if (reg_w > SAT_COLS) return SAT_COLS;
    return reg_w;
  endfunction

  function automatic int unsigned eff_h();
    if (reg_h < 1) return 1;
    if (reg_h > SAT_ROWS) return SAT_ROWS;
    return reg_h;
  endfunction

  function automatic bit [31:0] sat_read(int unsigned x, int unsigned y);
    if (x == 0 || y == 0) return 32'd0;
    return sat_mem[(y - 1) * SAT_COLS + (x - 1)];
  endfunction

  function automatic void sat_restart();
    row_acc  = 32'd0;
    col_pos  = 0;
    row_pos  = 0;
    img_done = 1'b0;
  endfunction

  function automatic void sat_config(cfg_reg_t idx, logic [CFG_DATA_BITS-1:0] d);
    if (idx == REG_IMAGE_WIDTH) reg_w = 32'(d);
    else reg_h = 32'(d[IMG_H_BITS-1:0]);
    sat_restart();
  endfunction

  // Applies one request to the table model; a query yields one expected response.
  function automatic void sat_apply(sat_req_t r, output bit has_res, output sat_resp_t res);
    int unsigned w;
    int unsigned h;
    bit [31:0]   above;
    w = eff_w();
    h = eff_h();
    has_res = 1'b0;
    res.area = 32'd0;
    res.status = ST_OK;
    if (r.mode == MODE_PIXEL) begin
      if (img_done) sat_restart();
      if (col_pos >= w || row_pos >= h) sat_restart();
      row_acc = row_acc + 32'(r.pixel);
      above = sat_read(col_pos + 1, row_pos);
      sat_mem[row_pos * SAT_COLS + col_pos] = above + row_acc;
      col_pos++;
      if (col_pos >= w) begin
        col_pos = 0;
        row_acc = 32'd0;
        row_pos++;
        if (row_pos >= h) begin
          row_pos  = 0;
          img_done = 1'b1;
        end
      end
    end else begin
      has_res = 1'b1;
      if (!img_done) begin
        res.status = ST_INCOMPLETE;
      end else if (32'(r.x0) > w || 32'(r.x1) > w || 32'(r.y0) > h || 32'(r.y1) > h) begin
        res.status = ST_RANGE;
      end else begin
        res.area = sat_read(32'(r.x1), 32'(r.y1)) - sat_read(32'(r.x1), 32'(r.y0))
                 - sat_read(32'(r.x0), 32'(r.y1)) + sat_read(32'(r.x0), 32'(r.y0));
      end
    end
  endfunction

  function automatic dir_row_t blank_row();
    dir_row_t row;
    row.is_cfg      = 1'b0;
    row.idx         = REG_IMAGE_WIDTH;
    row.data        = '0;
    row.req.mode    = MODE_PIXEL;
    row.req.pixel   = '0;
    row.req.x0      = '0;
    row.req.y0      = '0;
    row.req.x1      = '0;
    row.req.y1      = '0;
    row.typed       = 1'b0;
    row.want.area   = '0;
    row.want.status = ST_OK;
    return row;
  endfunction

  function automatic void add_cfg(cfg_reg_t idx, logic [CFG_DATA_BITS-1:0] d);
    dir_row_t row;
    row = blank_row();
    row.is_cfg = 1'b1;
    row.idx    = idx;
    row.data   = d;
    dir_rows.push_back(row);
  endfunction

  function automatic void add_px(logic [PIXEL_BITS-1:0] p);
    dir_row_t row;
    row = blank_row();
    row.req.mode  = MODE_PIXEL;
    row.req.pixel = p;
    dir_rows.push_back(row);
  endfunction

  function automatic void add_q(int unsigned x0, int unsigned y0, int unsigned x1,
                                int unsigned y1, bit typed, logic [31:0] area, status_t st);
    dir_row_t row;
    row = blank_row();
    row.req.mode    = MODE_QUERY;
    row.req.x0      = IMG_W_BITS'(x0);
    row.req.y0      = IMG_H_BITS'(y0);
    row.req.x1      = IMG_W_BITS'(x1);
    row.req.y1      = IMG_H_BITS'(y1);
    row.typed       = typed;
    row.want.area   = area;
    row.want.status = st;
    dir_rows.push_back(row);
  endfunction

  function automatic sat_req_t make_pixel();
    sat_req_t r;
    r.mode = MODE_PIXEL;
    case ($urandom_range(0, 9))
      0:       r.pixel = 8'd0;
      1:       r.pixel = 8'd255;
      default: r.pixel = PIXEL_BITS'($urandom_range(0, 255));
    endcase
    r.x0 = IMG_W_BITS'($urandom_range(0, 1023));
    r.y0 = IMG_H_BITS'($urandom_range(0, 511));
    r.x1 = IMG_W_BITS'($urandom_range(0, 1023));
    r.y1 = IMG_H_BITS'($urandom_range(0, 511));
    return r;
  endfunction

  function automatic sat_req_t make_query(int unsigned w, int unsigned h);
    sat_req_t    r;
    int unsigned pick;
    r.mode  = MODE_QUERY;
    r.pixel = PIXEL_BITS'($urandom_range(0, 255));
    pick = $urandom_range(0, 11);
    if (pick == 0) begin
      r.x0 = IMG_W_BITS'($urandom_range(0, 1023));
      r.y0 = IMG_H_BITS'($urandom_range(0, 511));
      r.x1 = IMG_W_BITS'($urandom_range(0, 1023));
      r.y1 = IMG_H_BITS'($urandom_range(0, 511));
    end else begin
      r.x0 = IMG_W_BITS'($urandom_range(0, w));
      r.y0 = IMG_H_BITS'($urandom_range(0, h));
      r.x1 = IMG_W_BITS'($urandom_range(0, w));
      r.y1 = IMG_H_BITS'($urandom_range(0, h));
      if (pick == 1) begin
        // One corner just past the image edge or anywhere beyond it.
        case ($urandom_range(0, 3))
          0: r.x0 = IMG_W_BITS'($urandom_range(0, 1) ? w + 1 : $urandom_range(w + 1, 1023));
          1: r.x1 = IMG_W_BITS'($urandom_range(0, 1) ? w + 1 : $urandom_range(w + 1, 1023));
          2: r.y0 = IMG_H_BITS'($urandom_range(0, 1) ? h + 1 : $urandom_range(h + 1, 511));
          default: r.y1 = IMG_H_BITS'($urandom_range(0, 1) ? h + 1 :
                                      $urandom_range(h + 1, 511));
        endcase
      end else if (pick == 2) begin
        r.x0 = '0;
        r.y0 = '0;
        r.x1 = IMG_W_BITS'(w);
        r.y1 = IMG_H_BITS'(h);
      end
    end
    return r;
  endfunction

  task automatic send_req(input sat_req_t r, input bit typed, input sat_resp_t want);
    bit        has_res;
    sat_resp_t res;
    if (!quiet && !send_calm && $urandom_range(0, 5) == 0) begin
      item_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    item_ch.valid     <= 1'b1;
    item_ch.mode      <= r.mode;
    item_ch.pixel     <= r.pixel;
    item_ch.corner_x0 <= r.x0;
    item_ch.corner_y0 <= r.y0;
    item_ch.corner_x1 <= r.x1;
    item_ch.corner_y1 <= r.y1;
    do @(posedge clk); while (item_ch.ready !== 1'b1);
    sat_apply(r, has_res, res);
    if (has_res) begin
      if (typed) res = want;
      pending_sums.push_back(res);
    end
    items_sent++;
    if (items_sent >= QUIET_FROM) quiet = 1'b1;
  endtask

  // Register writes wait until every query is answered and the last pixel has settled.
  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_BITS-1:0] d);
    item_ch.valid <= 1'b0;
    while (pending_sums.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= d;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    cfg_ch.valid <= 1'b0;
    sat_config(idx, d);
  endtask

  task automatic send_pixels(input int unsigned w, input int unsigned h,
                             input int unsigned count, input int unsigned noise_den);
    int unsigned k;
    for (k = 0; k < count; k++) begin
      if ($urandom_range(1, noise_den) == 1) send_req(make_query(w, h), 1'b0, no_want);
      send_req(make_pixel(), 1'b0, no_want);
    end
  endtask

  task automatic run_phase();
    int unsigned w;
    int unsigned h;
    int unsigned wdata;
    int unsigned hdata;
    int unsigned nimg;
    int unsigned nq;
    int unsigned i;
    int unsigned noise;
    bit          stripe;
    stripe = 1'b0;
    if (phase_no == 2) begin
      // Widest row, single line.
      stripe = 1'b1;
      case ($urandom_range(0, 2))
        0:       wdata = 640;
        1:       wdata = 1023;
        default: wdata = $urandom_range(641, 1023);
      endcase
      case ($urandom_range(0, 2))
        0:       hdata = 1;
        1:       hdata = 10'h201;
        default: hdata = 0;
      endcase
    end else if (phase_no == 5) begin
      // Tallest column, single pixel wide.
      stripe = 1'b1;
      wdata = $urandom_range(0, 1);
      hdata = $urandom_range(480, 511) | ($urandom_range(0, 1) << 9);
    end else if ($urandom_range(0, 5) == 0) begin
      wdata = $urandom_range(9, 24);
      hdata = $urandom_range(2, 8) | ($urandom_range(0, 1) << 9);
    end else begin
      wdata = $urandom_range(1, 8);
      hdata = $urandom_range(1, 6) | ($urandom_range(0, 1) << 9);
    end
    if ($urandom_range(0, 1)) begin
      write_reg(REG_IMAGE_WIDTH, CFG_DATA_BITS'(wdata));
      write_reg(REG_IMAGE_HEIGHT, CFG_DATA_BITS'(hdata));
    end else begin
      write_reg(REG_IMAGE_HEIGHT, CFG_DATA_BITS'(hdata));
      write_reg(REG_IMAGE_WIDTH, CFG_DATA_BITS'(wdata));
    end
    w = eff_w();
    h = eff_h();
    send_calm = ($urandom_range(0, 2) == 0);
    noise = stripe ? 64 : 10;
    if (!stripe && $urandom_range(0, 7) == 0) begin
      // Abandon a partial image with a register write, then build it again.
      send_pixels(w, h, $urandom_range(1, w * h), 4);
      write_reg(REG_IMAGE_WIDTH, CFG_DATA_BITS'(wdata));
    end
    nimg = (!stripe && $urandom_range(0, 2) == 0) ? 2 : 1;
    for (i = 0; i < nimg; i++) begin
      if (i > 0 && $urandom_range(0, 2) == 0) send_pixels(w, h, $urandom_range(1, w * h), 4);
      else send_pixels(w, h, w * h, noise);
      nq = stripe ? 6 : $urandom_range(3, 10);
      if (phase_no == 3 && i == 0) begin
        hold_go = 1'b1;
        nq = 12;
      end
      repeat (nq) send_req(make_query(w, h), 1'b0, no_want);
    end
    phase_no++;
  endtask

  // Result receiver: random short stalls, calm stretches, and one long hold.
  initial begin : result_sink
    int unsigned stall_left;
    int unsigned tick;
    bit          calm;
    bit          hold_done;
    stall_left = 0;
    tick = 0;
    calm = 1'b0;
    hold_done = 1'b0;
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      tick++;
      if (tick % 64 == 0) calm = ($urandom_range(0, 2) == 0);
      if (hold_go && !hold_done) begin
        hold_done = 1'b1;
        stall_left = LONG_HOLD - 1;
        result_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        result_ch.ready <= 1'b0;
      end else if (!quiet && !calm && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(0, 2);
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst !== 1'b1 && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
      if (pending_sums.size() == 0) begin
        $error("result with no pending query: area_sum %0d status %0d",
               result_ch.area_sum, result_ch.status);
        error_count++;
      end else begin
        got_want = pending_sums.pop_front();
        if (result_ch.area_sum !== got_want.area) begin
          $error("area_sum: expected %0d, actual %0d", got_want.area, result_ch.area_sum);
          error_count++;
        end
        if (result_ch.status !== got_want.status) begin
          $error("status: expected %0d, actual %0d", got_want.status, result_ch.status);
          error_count++;
        end
      end
      sums_checked++;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned n;
    items_sent   = 0;
    sums_checked = 0;
    error_count  = 0;
    cycle_count  = 0;
    phase_no     = 0;
    quiet        = 1'b0;
    send_calm    = 1'b0;
    hold_go      = 1'b0;
    no_want.area   = 32'd0;
    no_want.status = ST_OK;
    reg_w = 32'(WIDTH_RESET);
    reg_h = 32'(HEIGHT_RESET);
    sat_restart();

    rst                 <= 1'b1;
    item_ch.valid       <= 1'b0;
    item_ch.mode        <= MODE_PIXEL;
    item_ch.pixel       <= '0;
    item_ch.corner_x0   <= '0;
    item_ch.corner_y0   <= '0;
    item_ch.corner_x1   <= '0;
    item_ch.corner_y1   <= '0;
    cfg_ch.valid        <= 1'b0;
    cfg_ch.index        <= REG_IMAGE_WIDTH;
    cfg_ch.data         <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed rows: reset state, clamped registers, corners at and past the edge,
    // swapped corners, a new image after a complete one, and a restart mid-image.
    add_q(0, 0, 640, 480, 1'b1, 32'd0, ST_INCOMPLETE);
    add_cfg(REG_IMAGE_WIDTH, 10'd0);
    add_cfg(REG_IMAGE_HEIGHT, 10'h200);
    add_q(0, 0, 1, 1, 1'b1, 32'd0, ST_INCOMPLETE);
    add_px(8'd255);
    add_q(0, 0, 1, 1, 1'b1, 32'd255, ST_OK);
    add_q(1, 1, 0, 0, 1'b1, 32'd255, ST_OK);
    add_q(2, 0, 1, 1, 1'b1, 32'd0, ST_RANGE);
    add_q(0, 0, 1, 2, 1'b1, 32'd0, ST_RANGE);
    add_q(0, 0, 1023, 511, 1'b1, 32'd0, ST_RANGE);
    add_px(8'd0);
    add_q(0, 0, 1, 1, 1'b1, 32'd0, ST_OK);
    add_cfg(REG_IMAGE_WIDTH, 10'd2);
    add_cfg(REG_IMAGE_HEIGHT, 10'd2);
    add_px(8'd10);
    add_px(8'd20);
    add_px(8'd30);
    add_cfg(REG_IMAGE_WIDTH, 10'd2);
    add_q(0, 0, 2, 2, 1'b1, 32'd0, ST_INCOMPLETE);
    add_px(8'd10);
    add_px(8'd20);
    add_px(8'd30);
    add_px(8'd40);
    add_q(0, 2, 2, 0, 1'b0, 32'd0, ST_OK);
    add_q(1, 1, 2, 2, 1'b0, 32'd0, ST_OK);

    for (n = 0; n < dir_rows.size(); n++) begin
      if (dir_rows[n].is_cfg) write_reg(dir_rows[n].idx, dir_rows[n].data);
      else send_req(dir_rows[n].req, dir_rows[n].typed, dir_rows[n].want);
    end

    while (items_sent < ITEM_TARGET) run_phase();

    item_ch.valid <= 1'b0;
    while (pending_sums.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC * 2) @(posedge clk);
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
